FILE: rtl/core/smpq_pkg.sv
// Package: sizes, cell control and beat types for the sorted minimum priority queue.
package smpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int VALUE_BITS  = 16;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_value value;
    } t_cell_ctl;

    typedef struct packed {
        logic        mode;
        logic [15:0] priority_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] head_value;
        logic        queue_empty;
        logic        queue_full;
        logic [6:0]  occupancy;
        logic        op_error;
    } t_out_item;

endpackage

FILE: rtl/core/sorted_min_priority_queue.sv
// Top level: sorted minimum priority queue built from a chain of slot cells.
//
//  channel | direction | handshake                 | beat
//  in      | input     | i_in_valid / o_in_stall   | t_in_item  (mode, priority_value)
//  out     | output    | o_out_valid / i_out_stall | t_out_item (head, flags, occupancy)
//
// One push or pop per cycle unless stalled; result appears the cycle after acceptance.
// All slots compare against the pushed value at once and shift in the same cycle.
// Reset clears the entry count and output valid; slot contents are not cleared.
// The input stalls only while a result is held under output stall.
module sorted_min_priority_queue
    import smpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_count    r_count;
    t_count    n_count;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    logic      op_err;
    t_cell_ctl ctl;
    t_value    n_head;

    t_value    cell_value [QUEUE_DEPTH];
    logic      cell_lt    [QUEUE_DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_full    = (r_count == t_count'(QUEUE_DEPTH));
    assign is_empty   = (r_count == '0);

    always_comb begin
        op_err    = (i_in_item.mode == MODE_PUSH) ? is_full : is_empty;
        ctl.value = VALUE_BITS'(i_in_item.priority_value);
        ctl.push  = accept && (i_in_item.mode == MODE_PUSH) && !is_full;
        ctl.pop   = accept && (i_in_item.mode == MODE_POP) && !is_empty;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic   occ;
        t_value left_value;
        logic   left_lt;
        t_value right_value;

        assign occ = (t_count'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_value = ctl.value;
            assign left_lt    = 1'b1;
        end else begin : g_mid
            assign left_value = cell_value[g-1];
            assign left_lt    = cell_lt[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        smpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occ         (occ),
            .i_left_value  (left_value),
            .i_left_lt     (left_lt),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.push) begin
            n_count = r_count + t_count'(1);
        end else if (ctl.pop) begin
            n_count = r_count - t_count'(1);
        end

        if (ctl.push) begin
            n_head = cell_lt[0] ? cell_value[0] : ctl.value;
        end else if (ctl.pop) begin
            n_head = (QUEUE_DEPTH > 1) ? cell_value[1] : cell_value[0];
        end else begin
            n_head = cell_value[0];
        end

        n_out_item.head_value  = (n_count == '0) ? 16'd0 : 16'(n_head);
        n_out_item.queue_empty = (n_count == '0);
        n_out_item.queue_full  = (n_count == t_count'(QUEUE_DEPTH));
        n_out_item.occupancy   = 7'(n_count);
        n_out_item.op_error    = op_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_item.mode == MODE_PUSH) && !is_full
        |=> r_count == $past(r_count) + t_count'(1))
        else $error("push did not grow the queue");

    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && op_err |=> $stable(r_count) && o_out_item.op_error)
        else $error("refused operation changed the queue");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted beat gave no result");

    a_occ_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !accept |-> o_out_item.occupancy == 7'(r_count))
        else $error("reported occupancy differs from entry count");

endmodule

FILE: rtl/core/smpq_cell.sv
// One slot of the sorted chain: holds, shifts up on push, shifts down on pop.
module smpq_cell
    import smpq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_value    i_left_value,
    input  logic      i_left_lt,
    input  t_value    i_right_value,
    output t_value    o_value,
    output logic      o_lt
);

    t_value r_value;
    t_value n_value;

    assign o_lt = i_occ && (r_value < i_ctl.value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.push) begin
            if (o_lt) begin
                n_value = r_value;
            end else if (i_left_lt) begin
                n_value = i_ctl.value;
            end else begin
                n_value = i_left_value;
            end
        end else if (i_ctl.pop) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
